### design/slfps_pkg.sv
// Package for the sliding linear-fit peak scanner: sizes, payload types
// and the struct handed from the sum stage to the record stage. No dependencies.
package slfps_pkg;

  // Window and scan geometry
  localparam int HALF_WIDTH  = 8;
  localparam int WIN_LEN     = 2 * HALF_WIDTH + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int SCAN_LENGTH = 4096;

  // Field widths
  localparam int AMP_BITS   = 21;
  localparam int SLOPE_BITS = 23;
  localparam int DELTA_BITS = 22;
  localparam int LOC_BITS   = $clog2(SCAN_LENGTH);
  localparam int FILL_BITS  = $clog2(WIN_LEN + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AMP_BITS-1:0]    amp_t;
  typedef logic signed [SLOPE_BITS-1:0]  slope_t;
  typedef logic signed [DELTA_BITS-1:0]  delta_t;
  typedef logic        [LOC_BITS-1:0]    loc_t;
  typedef logic        [FILL_BITS-1:0]   fill_t;

  localparam loc_t   LOC_MAX = LOC_BITS'(SCAN_LENGTH - 1);
  localparam fill_t  FILL_FULL = FILL_BITS'(WIN_LEN);
  localparam fill_t  FILL_PRIME = FILL_BITS'(WIN_LEN - 1);
  localparam slope_t HW_S = SLOPE_BITS'(HALF_WIDTH);

  // Sum stage result, one per accepted request
  typedef struct packed {
    logic   restart;    // request carried start_req: clear the records
    logic   full;       // window holds WIN_LEN samples
    logic   upd;        // past the priming window: records may change
    amp_t   amp;        // amplitude sum
    slope_t slope;      // slope sum after this request
    slope_t prev_slope; // slope sum before this request
    delta_t delta;      // slope increment of this step
    loc_t   loc;        // location after this request
  } sums_t;

endpackage

### design/slfps_feed_if.sv
// Input channel of the peak scanner: one sample and the start flag per request.
// Depends on slfps_pkg.
interface slfps_feed_if;
  import slfps_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

### design/slfps_report_if.sv
// Output channel of the peak scanner: sums, crossing flag and the three records.
// Depends on slfps_pkg.
interface slfps_report_if;
  import slfps_pkg::*;

  logic   valid;
  logic   ready;
  logic   window_full;
  amp_t   amplitude_sum;
  slope_t slope_sum;
  logic   crossing_seen;
  slope_t rise_value;
  loc_t   rise_location;
  slope_t fall_value;
  loc_t   fall_location;
  amp_t   top_amplitude;
  loc_t   top_location;
  delta_t top_slope_delta;
  slope_t top_slope_estimate;

  modport source (output valid, window_full, amplitude_sum, slope_sum, crossing_seen,
                  rise_value, rise_location, fall_value, fall_location, top_amplitude,
                  top_location, top_slope_delta, top_slope_estimate,
                  input ready);
  modport sink   (input valid, window_full, amplitude_sum, slope_sum, crossing_seen,
                  rise_value, rise_location, fall_value, fall_location, top_amplitude,
                  top_location, top_slope_delta, top_slope_estimate,
                  output ready);
endinterface

### design/slfps_cell.sv
// One tap of the sample window: holds a sample and hands it on each shift.
// Depends on slfps_pkg.
module slfps_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              flush,
  input  slfps_pkg::sample_t din,
  output slfps_pkg::sample_t dout
);
  import slfps_pkg::*;

  sample_t data;

  // flush loads zero so a fresh scan sees an empty window
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= flush ? '0 : din;
    end
  end

  assign dout = data;
endmodule

### design/slfps_sums.sv
// Sum stage: chain of window cells plus the recursive amplitude and slope sums.
// Depends on slfps_pkg, slfps_feed_if, slfps_cell.
module slfps_sums (
  input  logic             clk,
  input  logic             rst,
  slfps_feed_if.sink       feed,
  input  logic             take,
  output logic             stage_valid,
  output slfps_pkg::sums_t stage
);
  import slfps_pkg::*;

  logic    accept;
  logic    start;
  logic    running;
  logic    priming;
  sample_t cell_data [WIN_LEN];
  fill_t   fill;
  fill_t   fill_next;
  loc_t    loc_next;
  sums_t   stage_next;
  slope_t  x;
  slope_t  low;
  slope_t  amp_base;
  slope_t  slope_base;
  slope_t  pair;
  slope_t  dslope;
  slope_t  amp_w;
  slope_t  slope_w;

  assign feed.ready = !stage_valid || take;
  assign accept     = feed.valid && feed.ready;
  assign start      = feed.start_req;

  // Window: cell 0 takes the new sample, the last cell holds the oldest
  for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      slfps_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .flush (1'b0),
        .din   (feed.sample),
        .dout  (cell_data[k])
      );
    end else begin : g_tail
      slfps_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .flush (start),
        .din   (cell_data[k-1]),
        .dout  (cell_data[k])
      );
    end
  end

  // Recursive update; a start behaves as an empty window with zero sums
  always_comb begin
    x          = SLOPE_BITS'(feed.sample);
    low        = start ? '0 : SLOPE_BITS'(cell_data[WIN_LEN-1]);
    amp_base   = start ? '0 : SLOPE_BITS'(stage.amp);
    slope_base = start ? '0 : stage.slope;
    pair       = x + low;
    dslope     = pair * HW_S - (amp_base - low);
    amp_w      = amp_base + x - low;
    slope_w    = slope_base + dslope;

    running = !start && (fill == FILL_FULL);
    priming = !start && (fill == FILL_PRIME);

    if (start) begin
      fill_next = FILL_BITS'(1);
    end else if (fill < FILL_FULL) begin
      fill_next = fill + FILL_BITS'(1);
    end else begin
      fill_next = fill;
    end

    // location restarts at the priming window, then saturates
    if (start || priming) begin
      loc_next = '0;
    end else if (running && (stage.loc != LOC_MAX)) begin
      loc_next = stage.loc + LOC_BITS'(1);
    end else begin
      loc_next = stage.loc;
    end

    stage_next.restart    = start;
    stage_next.full       = (fill_next == FILL_FULL);
    stage_next.upd        = running;
    stage_next.amp        = amp_w[AMP_BITS-1:0];
    stage_next.slope      = slope_w;
    stage_next.prev_slope = slope_base;
    stage_next.delta      = dslope[DELTA_BITS-1:0];
    stage_next.loc        = loc_next;
  end

  // Stage register doubles as the accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      fill        <= '0;
      stage       <= '0;
    end else begin
      if (accept) begin
        stage <= stage_next;
        fill  <= fill_next;
      end
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (take) begin
        stage_valid <= 1'b0;
      end
    end
  end
endmodule

### design/slfps_records.sv
// Record stage: rise, fall and top records plus the output register.
// Depends on slfps_pkg, slfps_report_if.
module slfps_records (
  input  logic             clk,
  input  logic             rst,
  input  logic             stage_valid,
  input  slfps_pkg::sums_t stage,
  output logic             take,
  slfps_report_if.source   report
);
  import slfps_pkg::*;

  logic   load;
  logic   valid;
  logic   full;
  amp_t   amp_o;
  slope_t slope_o;
  logic   crossing;
  logic   crossing_next;
  logic   rise_set;
  logic   fall_set;
  logic   top_set;
  logic   rise_ok;
  logic   fall_ok;
  logic   top_ok;
  slope_t rise_val;
  loc_t   rise_loc;
  slope_t fall_val;
  loc_t   fall_loc;
  amp_t   top_amp;
  loc_t   top_loc;
  delta_t top_delta;
  slope_t top_est;

  assign take = !valid || report.ready;
  assign load = take && stage_valid;

  // Record decisions; strict compare keeps the earlier location on a tie
  always_comb begin
    crossing_next = stage.upd && ($signed(stage.slope) < 0)
                    && ($signed(stage.prev_slope) > 0);
    rise_set = stage.upd && (!rise_ok || ($signed(stage.slope) > rise_val));
    fall_set = stage.upd && (!fall_ok || ($signed(stage.slope) < fall_val));
    top_set  = crossing_next && (!top_ok || ($signed(stage.amp) > top_amp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      rise_ok   <= 1'b0;
      fall_ok   <= 1'b0;
      top_ok    <= 1'b0;
      rise_val  <= '0;
      rise_loc  <= '0;
      fall_val  <= '0;
      fall_loc  <= '0;
      top_amp   <= '0;
      top_loc   <= '0;
      top_delta <= '0;
      top_est   <= '0;
    end else begin
      if (take) begin
        valid <= stage_valid;
      end
      if (load) begin
        if (stage.restart) begin
          rise_ok   <= 1'b0;
          fall_ok   <= 1'b0;
          top_ok    <= 1'b0;
          rise_val  <= '0;
          rise_loc  <= '0;
          fall_val  <= '0;
          fall_loc  <= '0;
          top_amp   <= '0;
          top_loc   <= '0;
          top_delta <= '0;
          top_est   <= '0;
        end else begin
          if (rise_set) begin
            rise_ok  <= 1'b1;
            rise_val <= stage.slope;
            rise_loc <= stage.loc;
          end
          if (fall_set) begin
            fall_ok  <= 1'b1;
            fall_val <= stage.slope;
            fall_loc <= stage.loc;
          end
          if (top_set) begin
            top_ok    <= 1'b1;
            top_amp   <= stage.amp;
            top_loc   <= stage.loc;
            top_delta <= stage.delta;
            top_est   <= stage.slope;
          end
        end
      end
    end
  end

  // Output payload; sums read as zero while the window fills
  always_ff @(posedge clk) begin
    if (load) begin
      full     <= stage.full;
      amp_o    <= stage.full ? stage.amp : '0;
      slope_o  <= stage.full ? stage.slope : '0;
      crossing <= crossing_next;
    end
  end

  assign report.valid              = valid;
  assign report.window_full        = full;
  assign report.amplitude_sum      = amp_o;
  assign report.slope_sum          = slope_o;
  assign report.crossing_seen      = crossing;
  assign report.rise_value         = rise_val;
  assign report.rise_location      = rise_loc;
  assign report.fall_value         = fall_val;
  assign report.fall_location      = fall_loc;
  assign report.top_amplitude      = top_amp;
  assign report.top_location       = top_loc;
  assign report.top_slope_delta    = top_delta;
  assign report.top_slope_estimate = top_est;
endmodule

### design/sliding_linear_fit_peak_scanner.sv
// Top level of the sliding linear-fit peak scanner.
// Depends on slfps_pkg, slfps_feed_if, slfps_report_if, slfps_sums, slfps_records.
//
//   channel  | dir | request content
//   ---------+-----+-------------------------------------------------------
//   feed     | in  | sample (16b signed), start_req
//   report   | out | window_full, sums, crossing flag, rise/fall/top records
//
// One request per cycle sustained while report does not stall; each request passes
// the sum stage register and then the record stage output register before report.
// The sum stage's recursive add of the new and oldest window samples sets the pace.
// rst (synchronous) empties the window, sums, location and records.
// A stall on report holds both stages; feed keeps accepting while the sum stage
// is empty, so one request can enter while a result waits.
module sliding_linear_fit_peak_scanner (
  input  logic           clk,
  input  logic           rst,
  slfps_feed_if.sink     feed,
  slfps_report_if.source report
);
  import slfps_pkg::*;

  logic  stage_valid;
  logic  take;
  sums_t stage;

  slfps_sums u_sums (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  slfps_records u_records (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .take        (take),
    .report      (report)
  );
endmodule

### dv/sliding_linear_fit_peak_scanner_tb.sv
// Self-checking bench for the sliding linear-fit peak scanner: randomised sample scans,
// an in-bench window/record predictor and a field-by-field report scoreboard.
// Depends on slfps_pkg, slfps_feed_if, slfps_report_if and the scanner RTL.
`timescale 1ns / 100ps

module sliding_linear_fit_peak_scanner_tb;
  import slfps_pkg::*;

  localparam int FEED_SIDE   = 0;
  localparam int REPORT_SIDE = 1;
  localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAMPLE_MIN  = -(2 ** (SAMPLE_BITS - 1));
  localparam int RANDOM_REQS = 1200;
  localparam int LONG_SCAN   = 300;  // one slow peaked scan to close the run

  typedef struct packed {
    sample_t sample;
    logic    start_req;
  } feed_req_t;

  typedef struct packed {
    logic   window_full;
    amp_t   amplitude_sum;
    slope_t slope_sum;
    logic   crossing_seen;
    slope_t rise_value;
    loc_t   rise_location;
    slope_t fall_value;
    loc_t   fall_location;
    amp_t   top_amplitude;
    loc_t   top_location;
    delta_t top_slope_delta;
    slope_t top_slope_estimate;
  } scan_report_t;

  logic clk;
  logic rst;

  slfps_feed_if   feed ();
  slfps_report_if report ();

  sliding_linear_fit_peak_scanner u_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .report (report)
  );

  always #5 clk = ~clk;

  feed_req_t    sample_q[$];
  scan_report_t scan_reports_q[$];
  int           mismatch_n;
  int           report_n;

  // Window and record model state
  longint scan_win [WIN_LEN];
  int     fill_n;
  int     head_n;
  longint amp_run;
  longint slope_run;
  longint slope_was;
  int     loc_n;
  longint rise_peak;
  longint fall_peak;
  int     rise_at;
  int     fall_at;
  longint crest_amp;
  longint crest_delta;
  longint crest_slope;
  int     crest_at;
  bit     rise_set;
  bit     fall_set;
  bit     crest_set;

  function automatic void clear_scan();
    foreach (scan_win[i]) scan_win[i] = 0;
    fill_n = 0;
    head_n = 0;
    amp_run = 0;
    slope_run = 0;
    slope_was = 0;
    loc_n = 0;
    rise_peak = 0;
    fall_peak = 0;
    rise_at = 0;
    fall_at = 0;
    crest_amp = 0;
    crest_delta = 0;
    crest_slope = 0;
    crest_at = 0;
    rise_set = 0;
    fall_set = 0;
    crest_set = 0;
  endfunction

  // Advance the window by one sample and return the report it should produce
  function automatic scan_report_t advance_scan(sample_t x, logic restart);
    scan_report_t r;
    longint xs;
    longint oldest;
    longint dslope;
    bit     full;
    bit     crossing;
    xs = longint'(x);
    full = 0;
    crossing = 0;
    if (restart) clear_scan();

    if (fill_n < WIN_LEN) begin
      // still filling; the last fill primes the sums and the previous slope
      scan_win[fill_n] = xs;
      fill_n++;
      if (fill_n == WIN_LEN) begin
        amp_run = 0;
        slope_run = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
          amp_run += scan_win[i];
          slope_run += longint'(i - HALF_WIDTH) * scan_win[i];
        end
        head_n = 0;
        slope_was = slope_run;
        loc_n = 0;
        full = 1;
      end
    end else begin
      // recursive update: drop the oldest, add the newest
      oldest = scan_win[head_n];
      scan_win[head_n] = xs;
      head_n = (head_n + 1) % WIN_LEN;
      slope_was = slope_run;
      dslope = longint'(HALF_WIDTH) * (xs + oldest) - (amp_run - oldest);
      slope_run += dslope;
      amp_run += xs - oldest;
      full = 1;
      if (loc_n < SCAN_LENGTH - 1) loc_n++;

      // strictly better only, so ties keep the earlier location
      if (!rise_set || slope_run > rise_peak) begin
        rise_set = 1;
        rise_peak = slope_run;
        rise_at = loc_n;
      end
      if (!fall_set || slope_run < fall_peak) begin
        fall_set = 1;
        fall_peak = slope_run;
        fall_at = loc_n;
      end
      if (slope_run < 0 && slope_was > 0) begin
        crossing = 1;
        if (!crest_set || amp_run > crest_amp) begin
          crest_set = 1;
          crest_amp = amp_run;
          crest_at = loc_n;
          crest_delta = dslope;
          crest_slope = slope_run;
        end
      end
    end

    r.window_full        = full;
    r.amplitude_sum      = full ? amp_t'(amp_run) : '0;
    r.slope_sum          = full ? slope_t'(slope_run) : '0;
    r.crossing_seen      = crossing;
    r.rise_value         = slope_t'(rise_peak);
    r.rise_location      = loc_t'(rise_at);
    r.fall_value         = slope_t'(fall_peak);
    r.fall_location      = loc_t'(fall_at);
    r.top_amplitude      = amp_t'(crest_amp);
    r.top_location       = loc_t'(crest_at);
    r.top_slope_delta    = delta_t'(crest_delta);
    r.top_slope_estimate = slope_t'(crest_slope);
    return r;
  endfunction

  // Pacing: stretches of calm (no waits) and stretches of random waits, drawn at random
  int calm_left [2];
  bit calm_on   [2];

  function automatic int draw_wait(int side);
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(4, 40);
      calm_on[side] = ($urandom_range(0, 2) == 0);
    end
    calm_left[side]--;
    return calm_on[side] ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic sample_t clip_sample(int v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  function automatic void push_request(sample_t s, logic st);
    feed_req_t q;
    q.sample = s;
    q.start_req = st;
    sample_q.push_back(q);
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_n++;
    if (mismatch_n <= 100) $display("t=%0t report %0d: %s", $time, report_n, what);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Driver: presents queued requests, predicts each one as it is accepted
  feed_req_t on_bus;
  bit        feed_busy;
  int        feed_gap;

  always @(posedge clk) begin
    if (rst) begin
      feed.valid <= 1'b0;
      feed_busy = 0;
      feed_gap = 0;
    end else begin
      if (feed.valid && feed.ready) begin
        scan_reports_q.push_back(advance_scan(on_bus.sample, on_bus.start_req));
        feed_busy = 0;
        feed_gap = draw_wait(FEED_SIDE);
      end else if (!feed_busy && feed_gap > 0) begin
        feed_gap--;
      end
      if (!feed_busy && feed_gap == 0 && sample_q.size() != 0) begin
        on_bus = sample_q.pop_front();
        feed.sample <= on_bus.sample;
        feed.start_req <= on_bus.start_req;
        feed_busy = 1;
      end
      feed.valid <= feed_busy;
    end
  end

  // Monitor: takes reports, compares against the oldest prediction, stalls at random
  int report_stall;

  always @(posedge clk) begin
    scan_report_t seen;
    scan_report_t want;
    if (rst) begin
      report.ready <= 1'b0;
      report_stall = 0;
    end else begin
      if (report.valid && report.ready) begin
        seen.window_full        = report.window_full;
        seen.amplitude_sum      = report.amplitude_sum;
        seen.slope_sum          = report.slope_sum;
        seen.crossing_seen      = report.crossing_seen;
        seen.rise_value         = report.rise_value;
        seen.rise_location      = report.rise_location;
        seen.fall_value         = report.fall_value;
        seen.fall_location      = report.fall_location;
        seen.top_amplitude      = report.top_amplitude;
        seen.top_location       = report.top_location;
        seen.top_slope_delta    = report.top_slope_delta;
        seen.top_slope_estimate = report.top_slope_estimate;
        if (scan_reports_q.size() == 0) begin
          flag_mismatch("report with no request pending");
        end else begin
          want = scan_reports_q.pop_front();
          check_field("window_full", seen.window_full, want.window_full);
          check_field("amplitude_sum", seen.amplitude_sum, want.amplitude_sum);
          check_field("slope_sum", seen.slope_sum, want.slope_sum);
          check_field("crossing_seen", seen.crossing_seen, want.crossing_seen);
          check_field("rise_value", seen.rise_value, want.rise_value);
          check_field("rise_location", seen.rise_location, want.rise_location);
          check_field("fall_value", seen.fall_value, want.fall_value);
          check_field("fall_location", seen.fall_location, want.fall_location);
          check_field("top_amplitude", seen.top_amplitude, want.top_amplitude);
          check_field("top_location", seen.top_location, want.top_location);
          check_field("top_slope_delta", seen.top_slope_delta, want.top_slope_delta);
          check_field("top_slope_estimate", seen.top_slope_estimate,
                      want.top_slope_estimate);
        end
        report_n++;
        report_stall = draw_wait(REPORT_SIDE);
      end else if (report_stall > 0) begin
        report_stall--;
      end
      report.ready <= (report_stall == 0);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int scan_len;
    int period;
    int lift;
    int base;
    int jitter;
    int level;
    int kind;
    int k2;
    int v;
    clk = 1'b0;
    rst = 1'b1;
    feed.valid = 1'b0;
    feed.sample = '0;
    feed.start_req = 1'b0;
    report.ready = 1'b0;
    mismatch_n = 0;
    report_n = 0;
    clear_scan();

    // restart while the window is still filling
    push_request(sample_t'(100), 1'b1);
    push_request(sample_t'(-5), 1'b0);
    // priming window at the positive rail: largest amplitude sum
    push_request(sample_t'(SAMPLE_MAX), 1'b1);
    for (int i = 0; i < WIN_LEN - 1; i++) push_request(sample_t'(SAMPLE_MAX), 1'b0);
    // negative rail and a swing back: first record updates
    push_request(sample_t'(SAMPLE_MIN), 1'b0);
    push_request(sample_t'(SAMPLE_MIN), 1'b0);
    push_request(sample_t'(SAMPLE_MAX), 1'b0);
    push_request(sample_t'(0), 1'b0);

    // random scans, mostly peaked waveforms that produce slope crossings
    while (sample_q.size() < RANDOM_REQS + 23) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        scan_len = $urandom_range(20, 160);
        period = $urandom_range(6, 64);
        lift = $urandom_range(0, 60000);
        base = int'($urandom_range(0, 40000)) - 20000;
        jitter = $urandom_range(0, 3000);
        for (int i = 0; i < scan_len; i++) begin
          k2 = 2 * (i % period) - period;
          if (k2 < 0) k2 = -k2;
          v = base + lift * (period - k2) / period
              + int'($urandom_range(0, 2 * jitter)) - jitter;
          push_request(clip_sample(v), (i == 0) || ($urandom_range(0, 199) == 0));
        end
      end else if (kind < 8) begin
        // full-range noise
        scan_len = $urandom_range(20, 80);
        for (int i = 0; i < scan_len; i++) push_request(sample_t'($urandom), i == 0);
      end else if (kind == 8) begin
        // flat level: repeated equal slopes exercise the tie rule
        scan_len = $urandom_range(20, 60);
        level = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < scan_len; i++) push_request(sample_t'(level), i == 0);
      end else begin
        // broken scan: restarted before the window fills
        scan_len = $urandom_range(1, WIN_LEN - 1);
        for (int i = 0; i < scan_len; i++) push_request(sample_t'($urandom), i == 0);
      end
    end

    // one long, slow peaked scan
    for (int i = 0; i < LONG_SCAN; i++) begin
      k2 = 2 * (i % 200) - 200;
      if (k2 < 0) k2 = -k2;
      v = -15000 + 30000 * (200 - k2) / 200 + int'($urandom_range(0, 1000)) - 500;
      push_request(clip_sample(v), i == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (sample_q.size() != 0 || feed_busy || scan_reports_q.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatch_n == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
